// File: hw/rtl/sps_pkg.sv
// Shared constants, payload types and sequencer states for the segmented prime sieve.
`timescale 1ns / 1ps
package sps_pkg;

  localparam int VALUE_BITS       = 32;
  localparam int LEN_BITS         = 7;
  localparam int MAX_SEGMENT      = 64;
  localparam int BASE_TABLE_DEPTH = 8192;
  localparam int BASE_IDX_BITS    = $clog2(BASE_TABLE_DEPTH);
  localparam int COUNT_BITS       = BASE_IDX_BITS + 1;
  localparam int PRIME_BITS       = 17;
  localparam int SIEVE_DEPTH      = 65538;
  localparam int SIEVE_ADDR_BITS  = $clog2(SIEVE_DEPTH);
  localparam int SQRT_IN_BITS     = VALUE_BITS + 1;
  localparam int ROOT_BITS        = 21;
  localparam logic [VALUE_BITS-1:0] CUTOFF_RESET = VALUE_BITS'(1000000);

  typedef struct packed {
    logic [VALUE_BITS-1:0] segment_low;
    logic [LEN_BITS-1:0]   segment_len;
  } in_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] prime;
    logic                  valid_res;
    logic                  last;
  } out_t;

  typedef enum logic [13:0] {
    S_IDLE    = 14'h0001,
    S_BROOT   = 14'h0002,
    S_INIT    = 14'h0004,
    S_BP_RD   = 14'h0008,
    S_BP_CHK  = 14'h0010,
    S_STRIKE  = 14'h0020,
    S_COL_RD  = 14'h0040,
    S_COL_CHK = 14'h0080,
    S_SROOT   = 14'h0100,
    S_PR_RD   = 14'h0200,
    S_PR_CHK  = 14'h0400,
    S_DIV     = 14'h0800,
    S_MARK    = 14'h1000,
    S_EMIT    = 14'h2000
  } state_t;

endpackage

// File: hw/rtl/sps_div.sv
// Bit-serial restoring divider that returns the remainder of a segment start by a base prime.
`timescale 1ns / 1ps
module sps_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [sps_pkg::VALUE_BITS-1:0] dividend,
  input  logic [sps_pkg::PRIME_BITS-1:0] divisor,
  output logic                           done,
  output logic [sps_pkg::PRIME_BITS-1:0] remainder
);
  import sps_pkg::*;

  localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [PRIME_BITS-1:0] rem_r, rem_nxt;
  logic [PRIME_BITS-1:0] dsr_r, dsr_nxt;
  logic [VALUE_BITS-1:0] dvd_r, dvd_nxt;
  logic [PRIME_BITS:0]   trial;

  // one quotient bit per cycle
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    dvd_nxt  = dvd_r;
    trial    = {rem_r, dvd_r[VALUE_BITS-1]};
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_BITS'(VALUE_BITS);
      rem_nxt = '0;
      dsr_nxt = divisor;
      dvd_nxt = dividend;
    end else if (run_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = PRIME_BITS'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[PRIME_BITS-1:0];
      end
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// File: hw/rtl/sps_isqrt.sv
// Bit-at-a-time integer square root, one trial square and compare per cycle.
`timescale 1ns / 1ps
module sps_isqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             go,
  input  logic [sps_pkg::SQRT_IN_BITS-1:0] radicand,
  output logic                             done,
  output logic [sps_pkg::ROOT_BITS-1:0]    root
);
  import sps_pkg::*;

  logic                    run_r, run_nxt;
  logic                    done_r, done_nxt;
  logic [ROOT_BITS-1:0]    bit_r, bit_nxt;
  logic [ROOT_BITS-1:0]    root_r, root_nxt;
  logic [SQRT_IN_BITS-1:0] rad_r, rad_nxt;
  logic [ROOT_BITS-1:0]    trial;
  logic [2*ROOT_BITS-1:0]  trial_sq;

  // keep the trial bit when its square still fits
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    root_nxt = root_r;
    rad_nxt  = rad_r;
    trial    = root_r | bit_r;
    trial_sq = trial * trial;
    if (go) begin
      run_nxt  = 1'b1;
      bit_nxt  = {1'b1, {(ROOT_BITS-1){1'b0}}};
      root_nxt = '0;
      rad_nxt  = radicand;
    end else if (run_r) begin
      if (trial_sq <= (2*ROOT_BITS)'(rad_r)) begin
        root_nxt = trial;
      end
      bit_nxt = bit_r >> 1;
      if (bit_r[0]) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    bit_r  <= bit_nxt;
    root_r <= root_nxt;
    rad_r  <= rad_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: hw/rtl/segmented_prime_sieve.sv
// Top level of the segmented prime sieve: sequencer, base prime tables and segment marks.
//
// Usage. Write the cutoff with cfg_we/cfg_data; the block then rebuilds its base prime
// table (primes up to isqrt(cutoff)+1) and holds busy high while it does: it
// initialises the small sieve, strikes its composites, then copies the primes over.
// A segment beat is taken when start is high and busy is low: in_data carries the
// segment start and length (saturated to 64). The block clamps the segment to
// cutoff+1, then for each base prime up to isqrt(end-1) runs a serial remainder and
// strikes its multiples, one mark per cycle. Results come at most one per cycle, as
// the output pass scans one value per cycle; each sits on out_data for one cycle
// with out_strobe high: the primes in ascending order, the last one flagged. A
// segment without primes gives one beat with valid_res low and last high. The
// receiver cannot stall. busy stays high until the last beat is driven and is low
// in the cycle that beat sits on the ports.
// After reset the cutoff is 1000000 and the base table is empty, so nothing is
// struck until the first cutoff write.
`timescale 1ns / 1ps
module segmented_prime_sieve (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  sps_pkg::in_t                   in_data,
  output logic                           out_strobe,
  output sps_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [sps_pkg::VALUE_BITS-1:0] cfg_data
);
  import sps_pkg::*;

  localparam int HI_BITS  = VALUE_BITS + 2;
  localparam int K_BITS   = SIEVE_ADDR_BITS + 1;
  localparam int OFF_BITS = PRIME_BITS + 1;
  localparam int SEG_IDX  = $clog2(MAX_SEGMENT);

  state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0]      cutoff_r, cutoff_nxt;
  logic [COUNT_BITS-1:0]      count_r, count_nxt;
  logic [SIEVE_ADDR_BITS-1:0] limit_r, limit_nxt;
  logic [SIEVE_ADDR_BITS-1:0] p_r, p_nxt;
  logic [K_BITS-1:0]          k_r, k_nxt;
  logic [COUNT_BITS-1:0]      j_r, j_nxt;
  logic [VALUE_BITS-1:0]      low_r, low_nxt;
  logic [HI_BITS-1:0]         high_r, high_nxt;
  logic [LEN_BITS-1:0]        n_r, n_nxt;
  logic [ROOT_BITS-1:0]       root_r, root_nxt;
  logic [PRIME_BITS-1:0]      bp_r, bp_nxt;
  logic [OFF_BITS-1:0]        off_r, off_nxt;
  logic [MAX_SEGMENT-1:0]     marks_r, marks_nxt;
  logic [VALUE_BITS-1:0]      val_r, val_nxt;
  out_t                       out_r, out_nxt;
  logic                       strobe_r, strobe_nxt;

  // memories
  logic [PRIME_BITS-1:0] base_mem [BASE_TABLE_DEPTH];
  logic                  sieve_mem [SIEVE_DEPTH];
  logic [PRIME_BITS-1:0] base_q;
  logic                  sieve_q;
  logic                  base_we;
  logic                  sieve_we, sieve_wd;
  logic [K_BITS-1:0]     sieve_wa;

  // square root unit (shared by both passes) and divider
  logic                    sq_go, sq_done;
  logic [SQRT_IN_BITS-1:0] sq_in;
  logic [ROOT_BITS-1:0]    sq_root;
  logic                    dv_go, dv_done;
  logic [PRIME_BITS-1:0]   dv_rem;

  // scratch
  logic [LEN_BITS-1:0]         len_sat;
  logic [HI_BITS-1:0]          hi_raw, hi_cl;
  logic [ROOT_BITS:0]          lim_w;
  logic [2*SIEVE_ADDR_BITS-1:0] psq;
  logic [2*PRIME_BITS-1:0]     bpsq;
  logic [HI_BITS-1:0]          st_a, st_b, st;

  sps_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .go(sq_go), .radicand(sq_in),
    .done(sq_done), .root(sq_root)
  );

  // divisor is the prime being loaded, taken as the divider starts
  sps_div u_div (
    .clk(clk), .rst_n(rst_n), .go(dv_go), .dividend(low_r), .divisor(bp_nxt),
    .done(dv_done), .remainder(dv_rem)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cutoff_nxt = cutoff_r;
    count_nxt  = count_r;
    limit_nxt  = limit_r;
    p_nxt      = p_r;
    k_nxt      = k_r;
    j_nxt      = j_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    n_nxt      = n_r;
    root_nxt   = root_r;
    bp_nxt     = bp_r;
    off_nxt    = off_r;
    marks_nxt  = marks_r;
    val_nxt    = val_r;
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    sq_go      = 1'b0;
    sq_in      = SQRT_IN_BITS'(cutoff_r);
    dv_go      = 1'b0;
    base_we    = 1'b0;
    sieve_we   = 1'b0;
    sieve_wd   = 1'b0;
    sieve_wa   = k_r;
    len_sat    = (in_data.segment_len > LEN_BITS'(MAX_SEGMENT)) ?
                 LEN_BITS'(MAX_SEGMENT) : in_data.segment_len;
    hi_raw     = HI_BITS'(in_data.segment_low) + HI_BITS'(len_sat);
    hi_cl      = (hi_raw > HI_BITS'(cutoff_r) + 1'b1) ? HI_BITS'(cutoff_r) + 1'b1 : hi_raw;
    lim_w      = (ROOT_BITS+1)'(sq_root) + 1'b1;
    psq        = (2*SIEVE_ADDR_BITS)'(p_r) * (2*SIEVE_ADDR_BITS)'(p_r);
    bpsq       = (2*PRIME_BITS)'(bp_r) * (2*PRIME_BITS)'(bp_r);
    st_a       = HI_BITS'(low_r) +
                 ((dv_rem != '0) ? HI_BITS'(bp_r - dv_rem) : HI_BITS'(0));
    st_b       = HI_BITS'(bpsq);
    st         = (st_a < st_b) ? st_b : st_a;

    if (cfg_we) begin
      // new cutoff: rebuild the base table
      cutoff_nxt = cfg_data;
      sq_in      = SQRT_IN_BITS'(cfg_data);
      sq_go      = 1'b1;
      state_nxt  = S_BROOT;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            low_nxt  = in_data.segment_low;
            high_nxt = hi_cl;
            val_nxt  = in_data.segment_low;
            if (hi_cl > HI_BITS'(in_data.segment_low)) begin
              n_nxt = LEN_BITS'(hi_cl - HI_BITS'(in_data.segment_low));
              for (int i = 0; i < MAX_SEGMENT; i++) begin
                marks_nxt[i] = (LEN_BITS'(i) < n_nxt) &&
                  ((HI_BITS'(in_data.segment_low) + HI_BITS'(i)) >= HI_BITS'(2));
              end
              sq_in     = SQRT_IN_BITS'(hi_cl - 1'b1);
              sq_go     = 1'b1;
              state_nxt = S_SROOT;
            end else begin
              n_nxt     = '0;
              marks_nxt = '0;
              state_nxt = S_EMIT;
            end
          end
        end
        S_BROOT: begin
          if (sq_done) begin
            limit_nxt = (lim_w > (ROOT_BITS+1)'(SIEVE_DEPTH - 1)) ?
                        SIEVE_ADDR_BITS'(SIEVE_DEPTH - 1) : SIEVE_ADDR_BITS'(lim_w);
            k_nxt     = '0;
            state_nxt = S_INIT;
          end
        end
        S_INIT: begin
          if (k_r <= K_BITS'(limit_r)) begin
            sieve_we = 1'b1;
            sieve_wd = (k_r >= K_BITS'(2));
            k_nxt    = k_r + 1'b1;
          end else begin
            p_nxt     = SIEVE_ADDR_BITS'(2);
            state_nxt = S_BP_RD;
          end
        end
        S_BP_RD: begin
          if (psq > (2*SIEVE_ADDR_BITS)'(limit_r)) begin
            p_nxt     = SIEVE_ADDR_BITS'(2);
            count_nxt = '0;
            state_nxt = S_COL_RD;
          end else begin
            state_nxt = S_BP_CHK;
          end
        end
        S_BP_CHK: begin
          if (sieve_q) begin
            k_nxt     = K_BITS'(psq);
            state_nxt = S_STRIKE;
          end else begin
            p_nxt     = p_r + 1'b1;
            state_nxt = S_BP_RD;
          end
        end
        S_STRIKE: begin
          if (k_r <= K_BITS'(limit_r)) begin
            sieve_we = 1'b1;
            sieve_wd = 1'b0;
            k_nxt    = k_r + K_BITS'(p_r);
          end else begin
            p_nxt     = p_r + 1'b1;
            state_nxt = S_BP_RD;
          end
        end
        S_COL_RD: begin
          if (p_r > limit_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_COL_CHK;
          end
        end
        S_COL_CHK: begin
          if (sieve_q && count_r < COUNT_BITS'(BASE_TABLE_DEPTH)) begin
            base_we   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          p_nxt     = p_r + 1'b1;
          state_nxt = S_COL_RD;
        end
        S_SROOT: begin
          if (sq_done) begin
            root_nxt  = sq_root;
            j_nxt     = '0;
            state_nxt = S_PR_RD;
          end
        end
        S_PR_RD: begin
          if (j_r >= count_r) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_PR_CHK;
          end
        end
        S_PR_CHK: begin
          bp_nxt = base_q;
          if (ROOT_BITS'(base_q) > root_r) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_DIV;
          end
        end
        S_DIV: begin
          if (dv_done) begin
            if (st < high_r) begin
              off_nxt   = OFF_BITS'(st - HI_BITS'(low_r));
              state_nxt = S_MARK;
            end else begin
              j_nxt     = j_r + 1'b1;
              state_nxt = S_PR_RD;
            end
          end
        end
        S_MARK: begin
          if (off_r < OFF_BITS'(n_r)) begin
            marks_nxt[off_r[SEG_IDX-1:0]] = 1'b0;
            off_nxt = off_r + OFF_BITS'(bp_r);
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_PR_RD;
          end
        end
        S_EMIT: begin
          if (marks_r == '0) begin
            strobe_nxt        = 1'b1;
            out_nxt.prime     = '0;
            out_nxt.valid_res = 1'b0;
            out_nxt.last      = 1'b1;
            state_nxt         = S_IDLE;
          end else begin
            if (marks_r[0]) begin
              strobe_nxt        = 1'b1;
              out_nxt.prime     = val_r;
              out_nxt.valid_res = 1'b1;
              out_nxt.last      = (marks_r[MAX_SEGMENT-1:1] == '0);
              if (marks_r[MAX_SEGMENT-1:1] == '0) begin
                state_nxt = S_IDLE;
              end
            end
            marks_nxt = marks_r >> 1;
            val_nxt   = val_r + 1'b1;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
    // divider kicks off as it enters its wait state
    dv_go = !cfg_we && (state_r == S_PR_CHK) && (state_nxt == S_DIV);
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cutoff_r <= CUTOFF_RESET;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cutoff_r <= cutoff_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
    limit_r <= limit_nxt;
    p_r     <= p_nxt;
    k_r     <= k_nxt;
    j_r     <= j_nxt;
    low_r   <= low_nxt;
    high_r  <= high_nxt;
    n_r     <= n_nxt;
    root_r  <= root_nxt;
    bp_r    <= bp_nxt;
    off_r   <= off_nxt;
    marks_r <= marks_nxt;
    val_r   <= val_nxt;
    out_r   <= out_nxt;
  end

  // base prime table
  always_ff @(posedge clk) begin
    if (base_we) begin
      base_mem[count_r[BASE_IDX_BITS-1:0]] <= p_r[PRIME_BITS-1:0];
    end
    base_q <= base_mem[j_r[BASE_IDX_BITS-1:0]];
  end

  // small sieve bits
  always_ff @(posedge clk) begin
    if (sieve_we) begin
      sieve_mem[sieve_wa[SIEVE_ADDR_BITS-1:0]] <= sieve_wd;
    end
    sieve_q <= sieve_mem[p_r];
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

// File: bench/segmented_prime_sieve_tb.sv
// Self-checking testbench for the segmented prime sieve: directed and random segments.
`timescale 1ns / 1ps
module segmented_prime_sieve_tb;
  import sps_pkg::*;

  logic clk, rst_n, start, busy, out_strobe, cfg_we;
  in_t in_data;
  out_t out_data;
  logic [VALUE_BITS-1:0] cfg_data;
  int unsigned errors = 0;
  longint unsigned cycles = 0;
  bit no_gaps = 0;

  localparam longint unsigned CYCLE_LIMIT = 64'd100_000_000;

  segmented_prime_sieve dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  task automatic report(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // Predicts the primes of each segment and holds them until they come out
  class prime_scoreboard;
    longint unsigned cutoff;
    int unsigned base_list[$];
    out_t pending[$];

    function new();
      cutoff = 64'(CUTOFF_RESET);
    endfunction

    function longint unsigned int_root(longint unsigned n);
      longint unsigned r, t;
      r = 0;
      for (longint unsigned b = 64'd1 << 20; b != 0; b >>= 1) begin
        t = r + b;
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    // Rebuild base primes up to isqrt(cutoff)+1 after a cutoff write
    function void set_cutoff(logic [VALUE_BITS-1:0] v);
      longint unsigned lim;
      bit composite[];
      cutoff = v;
      lim = int_root(cutoff) + 1;
      if (lim > SIEVE_DEPTH - 1) lim = SIEVE_DEPTH - 1;
      composite = new[lim + 1];
      base_list.delete();
      for (longint unsigned p = 2; p * p <= lim; p++)
        if (!composite[p])
          for (longint unsigned k = p * p; k <= lim; k += p) composite[k] = 1;
      for (longint unsigned p = 2; p <= lim; p++)
        if (!composite[p] && base_list.size() < BASE_TABLE_DEPTH)
          base_list.insert(base_list.size(), 32'(p));
    endfunction

    function void note_segment(in_t seg);
      longint unsigned lo, len, hi, root, p, k, s;
      bit keep[64];
      int found;
      out_t r;
      lo = seg.segment_low;
      len = seg.segment_len;
      found = 0;
      if (len > MAX_SEGMENT) len = MAX_SEGMENT;
      hi = lo + len;
      if (hi > cutoff + 1) hi = cutoff + 1;
      if (hi > lo) begin
        for (int i = 0; i < 64; i++) keep[i] = 1;
        root = int_root(hi - 1);
        foreach (base_list[j]) begin
          p = base_list[j];
          if (p > root) break;
          s = ((lo + p - 1) / p) * p;
          if (s < p * p) s = p * p;
          for (k = s; k < hi; k += p) keep[k - lo] = 0;
        end
        for (longint unsigned i = 0; i < hi - lo; i++)
          if (keep[i] && lo + i >= 2) begin
            r.prime = VALUE_BITS'(lo + i);
            r.valid_res = 1'b1;
            r.last = 1'b0;
            pending.insert(pending.size(), r);
            found++;
          end
      end
      if (found == 0) begin
        r = '0;
        r.last = 1'b1;
        pending.insert(pending.size(), r);
      end else begin
        pending[pending.size() - 1].last = 1'b1;
      end
    endfunction

    task check_beat(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat prime=%0d", got.prime));
        return;
      end
      want = pending.pop_front();
      if (got.prime !== want.prime)
        report($sformatf("prime %0d, expected %0d", got.prime, want.prime));
      if (got.valid_res !== want.valid_res)
        report($sformatf("valid_res %b, expected %b", got.valid_res, want.valid_res));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b", got.last, want.last));
    endtask
  endclass

  prime_scoreboard sb = new();

  // Result monitor and cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_strobe) sb.check_beat(out_data);
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_segment(input logic [VALUE_BITS-1:0] lo, input logic [LEN_BITS-1:0] len);
    in_t seg;
    seg.segment_low = lo;
    seg.segment_len = len;
    // the block is busy right after a beat anyway
    @(posedge clk);
    // random idle cycles before the beat
    while (!no_gaps && $urandom_range(99) < 16) @(posedge clk);
    start <= 1'b1;
    in_data <= seg;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_segment(seg);
    start <= 1'b0;
    in_data <= {$urandom(), 7'($urandom())};
  endtask

  // Wait for all results, plus a short settle, before touching the cutoff
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_cutoff(input logic [VALUE_BITS-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_cutoff(v);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Mostly small or modest segment starts, some anywhere
  function automatic logic [VALUE_BITS-1:0] pick_low(longint unsigned cut);
    case ($urandom_range(3))
      0: return $urandom_range(200);
      1: return (cut > 70) ? VALUE_BITS'(cut - $urandom_range(70)) : $urandom_range(80);
      2: return $urandom_range(30000);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [VALUE_BITS-1:0] cuts[6];
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty base table: every value from 2 comes out
    send_segment(0, 20);
    send_segment(999_990, 64);
    send_segment(1_000_001, 5);
    send_segment(32'hFFFF_FFFF, 7'h7F);
    write_cutoff(1);
    send_segment(0, 64);
    write_cutoff(2);
    send_segment(0, 3);
    send_segment(2, 1);
    write_cutoff(0);
    send_segment(0, 64);
    write_cutoff(1000);
    send_segment(0, 64);
    send_segment(990, 64);
    send_segment(24, 5);   // no primes
    send_segment(5, 0);    // zero length
    send_segment(100, 127);// saturated length
    send_segment(1001, 3); // above cutoff
    write_cutoff(32'hFFFF_FFFF);
    send_segment(32'hFFFF_FFC0, 64);
    send_segment(32'hFFFF_FFFB, 1);
    send_segment(7, 1);
    send_segment(0, 1);
    send_segment(32'hAAAA_5555, 64);

    // Random phases through several cutoffs
    cuts = '{32'd97, 32'd65536, 32'($urandom_range(5000)), 32'd4_000_000,
             32'($urandom()), 32'hFFFF_FFFF};
    for (int ph = 0; ph < 6; ph++) begin
      write_cutoff(cuts[ph]);
      no_gaps = (ph == 2);
      for (int n = 0; n < 16; n++)
        send_segment(pick_low(sb.cutoff), ($urandom_range(9) == 0) ?
                     7'($urandom()) : 7'($urandom_range(64, 1)));
    end

    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
